/* src/bpwm_pkg.sv */
package bpwm_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = 1;
    localparam int DUTY_W   = 14;
    localparam int PRESC_W  = 16;
    localparam int ERR_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CYCLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_INVERT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_INVERT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_ENABLE   = 3'd4;

    localparam logic [DUTY_W-1:0]   FULL_CYCLE_RST = 14'd1000;
    localparam logic [PRESC_W-1:0]  PRESCALE_RST   = 16'd0;
    localparam logic [CHANNELS-1:0] MAIN_INV_RST   = 2'b00;
    localparam logic [CHANNELS-1:0] SEC_INV_RST    = 2'b11;
    localparam logic [CHANNELS-1:0] SEC_EN_RST     = 2'b11;

    typedef struct packed {
        logic              kind;
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] duty;
    } t_in_word;

    typedef struct packed {
        logic [CHANNELS-1:0] main_levels;
        logic [CHANNELS-1:0] second_levels;
    } t_out_word;

endpackage

/* src/bresenham_pwm_multichannel.sv */
// A tick word that steps the channels shows its result in the cycle after acceptance.
// Throughput: one word per cycle; the step of all channels is a single registered pass.
// The input is held off only while a result is waiting and the output side is stalled.
// Reset is synchronous and active low: registers take their reset values, every channel
// has its duty pending, and no result is held.
module bresenham_pwm_multichannel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bpwm_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bpwm_pkg::t_out_word                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bpwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [bpwm_pkg::DUTY_W-1:0]   r_full_cycle;
    logic [bpwm_pkg::PRESC_W-1:0]  r_presc_period;
    logic [bpwm_pkg::CHANNELS-1:0] r_main_inv;
    logic [bpwm_pkg::CHANNELS-1:0] r_sec_inv;
    logic [bpwm_pkg::CHANNELS-1:0] r_sec_en;

    logic [bpwm_pkg::PRESC_W-1:0]  r_presc_count;
    logic [bpwm_pkg::ERR_W-1:0]    r_err   [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::DUTY_W-1:0]   r_cnt   [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::DUTY_W-1:0]   r_duty  [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::DUTY_W-1:0]   r_pduty [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::CHANNELS-1:0] r_pflag;

    logic [bpwm_pkg::ERR_W-1:0]    n_err   [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::DUTY_W-1:0]   n_cnt   [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::DUTY_W-1:0]   n_duty  [bpwm_pkg::CHANNELS];
    logic [bpwm_pkg::CHANNELS-1:0] n_levels;

    logic                          r_out_valid;
    bpwm_pkg::t_out_word           r_out_data;

    logic                          accept;
    logic                          is_tick;
    logic                          is_set;
    logic                          do_step;
    logic [bpwm_pkg::ERR_W-1:0]    half_cycle;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign is_tick     = accept && (i_in_data.kind == bpwm_pkg::KIND_TICK);
    assign is_set      = accept && (i_in_data.kind == bpwm_pkg::KIND_SET);
    assign do_step     = is_tick && (r_presc_count == '0);
    assign half_cycle  = {{(bpwm_pkg::ERR_W-bpwm_pkg::DUTY_W){1'b0}}, r_full_cycle >> 1};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Each channel steps independently: load a pending duty, diffuse the error, wrap the cycle.
    always_comb begin
        logic [bpwm_pkg::DUTY_W-1:0] duty_sel;
        logic [bpwm_pkg::DUTY_W-1:0] duty_clip;
        logic [bpwm_pkg::ERR_W-1:0]  err_base;
        logic [bpwm_pkg::DUTY_W-1:0] cnt_base;
        logic [bpwm_pkg::ERR_W:0]    diff;
        logic [bpwm_pkg::ERR_W-1:0]  err_new;
        logic [bpwm_pkg::DUTY_W-1:0] cnt_new;
        for (int c = 0; c < bpwm_pkg::CHANNELS; c++) begin
            duty_sel  = r_pflag[c] ? r_pduty[c] : r_duty[c];
            err_base  = r_pflag[c] ? half_cycle : r_err[c];
            cnt_base  = r_pflag[c] ? '0 : r_cnt[c];
            duty_clip = (duty_sel < r_full_cycle) ? duty_sel : r_full_cycle;
            diff = {1'b0, err_base}
                 - {{(bpwm_pkg::ERR_W+1-bpwm_pkg::DUTY_W){1'b0}}, duty_clip};
            if (diff[bpwm_pkg::ERR_W]) begin
                err_new = diff[bpwm_pkg::ERR_W-1:0]
                        + {{(bpwm_pkg::ERR_W-bpwm_pkg::DUTY_W){1'b0}}, r_full_cycle};
                n_levels[c] = 1'b1;
            end else begin
                err_new = diff[bpwm_pkg::ERR_W-1:0];
                n_levels[c] = 1'b0;
            end
            cnt_new = cnt_base + 1'b1;
            if (cnt_new >= r_full_cycle) begin
                n_cnt[c] = '0;
                n_err[c] = half_cycle;
            end else begin
                n_cnt[c] = cnt_new;
                n_err[c] = err_new;
            end
            n_duty[c] = duty_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_cycle   <= bpwm_pkg::FULL_CYCLE_RST;
            r_presc_period <= bpwm_pkg::PRESCALE_RST;
            r_main_inv     <= bpwm_pkg::MAIN_INV_RST;
            r_sec_inv      <= bpwm_pkg::SEC_INV_RST;
            r_sec_en       <= bpwm_pkg::SEC_EN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpwm_pkg::CFG_FULL_CYCLE: begin
                    r_full_cycle <= i_cfg_data[bpwm_pkg::DUTY_W-1:0];
                end
                bpwm_pkg::CFG_PRESCALE: begin
                    r_presc_period <= i_cfg_data[bpwm_pkg::PRESC_W-1:0];
                end
                bpwm_pkg::CFG_MAIN_INVERT: begin
                    r_main_inv <= i_cfg_data[bpwm_pkg::CHANNELS-1:0];
                end
                bpwm_pkg::CFG_SEC_INVERT: begin
                    r_sec_inv <= i_cfg_data[bpwm_pkg::CHANNELS-1:0];
                end
                bpwm_pkg::CFG_SEC_ENABLE: begin
                    r_sec_en <= i_cfg_data[bpwm_pkg::CHANNELS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc_count <= '0;
            r_pflag       <= '1;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < bpwm_pkg::CHANNELS; c++) begin
                r_err[c]   <= '0;
                r_cnt[c]   <= '0;
                r_duty[c]  <= '0;
                r_pduty[c] <= '0;
            end
        end else begin
            if (is_set) begin
                r_pduty[i_in_data.channel] <= i_in_data.duty;
                r_pflag[i_in_data.channel] <= 1'b1;
            end
            if (is_tick) begin
                if (do_step) begin
                    r_presc_count <= r_presc_period;
                end else begin
                    r_presc_count <= r_presc_count - 1'b1;
                end
            end
            if (do_step) begin
                r_pflag <= '0;
                for (int c = 0; c < bpwm_pkg::CHANNELS; c++) begin
                    r_err[c]  <= n_err[c];
                    r_cnt[c]  <= n_cnt[c];
                    r_duty[c] <= n_duty[c];
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_data.main_levels   <= n_levels ^ r_main_inv;
            r_out_data.second_levels <= (n_levels ^ r_sec_inv) & r_sec_en;
        end
    end

endmodule
